[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk while rst is low.
`define RABC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define RABC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/rabc_pkg.sv]
package rabc_pkg;

  // Widths of the fixed fields.
  localparam int unsigned POS_W  = 11;
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned CNT_W  = 11;

  // Value of the size register after reset.
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  // Depth of the queue between front and back.
  localparam int unsigned QDEPTH = 2;

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic [POS_W-1:0]  first0;      // first position minus one
    logic [POS_W-1:0]  last0;       // last position minus one
    logic              mark_value;
    logic              range_error;
    logic [SIZE_W-1:0] lim;         // effective size at acceptance
  } entry_t;

  // Control from the back part to the front part.
  typedef struct packed {
    logic pop;       // head entry taken this cycle
    logic clearing;  // bitmap initialisation sweep running
  } back_status_t;

  // Sequencer states of the back part.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

[rtl/rabc_ram.sv]
module rabc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/rabc_back.sv]
module rabc_back
  import rabc_pkg::*;
#(
  parameter int unsigned POSITIONS = 1024,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  entry_t       q_head,
  output back_status_t status,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [15:0]  m_axis_tdata,   // set_count [10:0], zero [15:11]
  output logic         m_axis_tuser    // range_error [0]
);

`include "assert_macros.svh"

  localparam int unsigned NWORDS = (POSITIONS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned BW     = $clog2(WORD_BITS);
  localparam int unsigned OW     = $clog2(WORD_BITS + 1);
  localparam int unsigned PB     = $clog2(NWORDS * WORD_BITS + 1);
  localparam int unsigned DW     = ((PB > POS_W) ? PB : POS_W) + 1;
  localparam logic [AW-1:0]        LAST_WORD = AW'(NWORDS - 1);
  localparam logic [WORD_BITS-1:0] ONES      = {WORD_BITS{1'b1}};
  localparam logic signed [DW-1:0] WB_S      = DW'(WORD_BITS);

  state_t state, state_next;

  entry_t               job;
  logic [AW-1:0]        addr;
  logic [PB-1:0]        rd_base;
  logic                 s1_valid;
  logic [AW-1:0]        s1_addr;
  logic [PB-1:0]        s1_base;
  logic [CNT_W-1:0]     count;
  logic                 out_valid;
  logic [CNT_W-1:0]     out_count;
  logic                 out_error;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic                 load_out;

  logic signed [DW-1:0] lo_off, hi_off, n_off;
  logic [BW-1:0]        lo_clip, hi_clip;
  logic                 range_hit;
  logic [WORD_BITS-1:0] range_mask, count_mask, new_word, counted;
  logic [OW-1:0]        word_ones;

  rabc_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(NWORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Offsets of the range ends and of the size limit within the word in stage one.
  always_comb begin
    lo_off = $signed(DW'(job.first0)) - $signed(DW'(s1_base));
    hi_off = $signed(DW'(job.last0)) - $signed(DW'(s1_base));
    n_off  = $signed(DW'(job.lim)) - $signed(DW'(s1_base));
  end

  // Masks of the bits to assign and of the bits that count.
  always_comb begin
    lo_clip    = lo_off[DW-1] ? '0 : lo_off[BW-1:0];
    hi_clip    = (hi_off >= WB_S) ? BW'(WORD_BITS - 1) : hi_off[BW-1:0];
    range_hit  = !job.range_error && !hi_off[DW-1] && (lo_off < WB_S);
    range_mask = (ONES << lo_clip) & (ONES >> (BW'(WORD_BITS - 1) - hi_clip));
    if (n_off[DW-1] || (n_off == '0)) begin
      count_mask = '0;
    end else if (n_off >= WB_S) begin
      count_mask = ONES;
    end else begin
      count_mask = ~(ONES << n_off[BW-1:0]);
    end
  end

  // Rewritten word and its population over the positions in use.
  always_comb begin
    word_ones = '0;
    if (range_hit) begin
      new_word = (ram_rdata & ~range_mask) | (range_mask & {WORD_BITS{job.mark_value}});
    end else begin
      new_word = ram_rdata;
    end
    counted = new_word & count_mask;
    for (int i = 0; i < WORD_BITS; i++) begin
      word_ones = word_ones + OW'(counted[i]);
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (addr == LAST_WORD) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (addr == LAST_WORD) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || m_axis_tready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Memory controls, queue pop and result load.
  always_comb begin
    ram_we          = s1_valid;
    ram_waddr       = s1_addr;
    ram_wdata       = new_word;
    ram_re          = 1'b0;
    ram_raddr       = addr;
    status.pop      = 1'b0;
    status.clearing = 1'b0;
    load_out        = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we          = 1'b1;
        ram_waddr       = addr;
        ram_wdata       = ONES;
        status.clearing = 1'b1;
      end
      ST_IDLE: begin
        status.pop = q_valid;
      end
      ST_SWEEP: begin
        ram_re = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_DONE: begin
        load_out = !out_valid || m_axis_tready;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, word pipeline and count accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      addr     <= '0;
      s1_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= (state == ST_SWEEP);
      s1_addr  <= addr;
      s1_base  <= rd_base;
      if (s1_valid) begin
        count <= count + CNT_W'(word_ones);
      end
      unique case (state)
        ST_CLEAR: begin
          addr <= (addr == LAST_WORD) ? '0 : addr + 1'b1;
        end
        ST_IDLE: begin
          if (q_valid) begin
            job     <= q_head;
            addr    <= '0;
            rd_base <= '0;
            count   <= '0;
          end
        end
        ST_SWEEP: begin
          addr    <= (addr == LAST_WORD) ? '0 : addr + 1'b1;
          rd_base <= rd_base + PB'(WORD_BITS);
        end
        ST_DRAIN, ST_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: holds one result until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
        out_count <= count;
        out_error <= job.range_error;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_count};
  assign m_axis_tuser  = out_error;

  // The write-back stage only runs while a sweep is in flight.
  `RABC_ASSERT(a_s1_in_sweep, s1_valid |-> (state == ST_SWEEP || state == ST_DRAIN), "write-back outside sweep")
  // A read never targets the word written back in the same cycle.
  `RABC_ASSERT(a_no_rw_clash, (ram_we && ram_re) |-> (ram_waddr != ram_raddr), "read and write on one word")
  // The queue is popped only when it holds an entry.
  `RABC_ASSERT(a_pop_valid, status.pop |-> q_valid, "pop from empty queue")

endmodule

[rtl/rabc_front.sv]
module rabc_front
  import rabc_pkg::*;
#(
  parameter int unsigned POSITIONS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data,      // size_in_use [10:0]
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,  // first_pos [10:0], last_pos [21:11],
                                           // mark_value [22], zero [23]
  input  back_status_t      status,
  output logic              q_valid,
  output entry_t            q_head
);

`include "assert_macros.svh"

  localparam int unsigned QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCW = $clog2(QDEPTH + 1);

  logic [SIZE_W-1:0] size_in_use;
  logic [POS_W-1:0]  first_pos, last_pos;
  logic              mark_value;
  logic [SIZE_W-1:0] lim;
  entry_t            item;

  entry_t            q_mem [QDEPTH];
  logic [QPW-1:0]    wr_ptr, rd_ptr;
  logic [QCW-1:0]    q_count;
  logic              push;

  // Size register; the channel is always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_RESET;
    end else if (cfg_valid) begin
      size_in_use <= cfg_data;
    end
  end

  // Classify the incoming item against the effective size.
  always_comb begin
    first_pos  = s_axis_tdata[10:0];
    last_pos   = s_axis_tdata[21:11];
    mark_value = s_axis_tdata[22];
    lim        = (32'(size_in_use) > POSITIONS) ? SIZE_W'(POSITIONS) : size_in_use;
    item.first0      = first_pos - 1'b1;
    item.last0       = last_pos - 1'b1;
    item.mark_value  = mark_value;
    item.range_error = (first_pos == '0) || (first_pos > last_pos) || (last_pos > lim);
    item.lim         = lim;
  end

  // No item is taken while the bitmap is being initialised.
  assign s_axis_tready = (q_count != QCW'(QDEPTH)) && !status.clearing;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (q_count != '0);
  assign q_head        = q_mem[rd_ptr];

  // Queue of classified items.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        q_mem[wr_ptr] <= item;
        wr_ptr <= (wr_ptr == QPW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (status.pop) begin
        rd_ptr <= (rd_ptr == QPW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !status.pop) begin
        q_count <= q_count + 1'b1;
      end else if (!push && status.pop) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

  // An accepted item is in the queue on the next cycle.
  `RABC_ASSERT(a_push_lands, push |=> (q_count != '0), "accepted item lost")
  // Nothing is accepted during the initialisation sweep.
  `RABC_ASSERT(a_no_take_clear, push |-> !status.clearing, "item taken during clear")

endmodule

[rtl/range_assign_bit_counter_unit.sv]
// Each item sweeps the whole bitmap, one word per cycle through the RAM, and the back
// part finishes one item before it takes the next one from the queue.
// Up to two classified items wait in the queue while the sweep runs.
// Reset is synchronous; after it a pass over every word sets every mark and no item
// is accepted until it ends (configuration writes are taken throughout).
module range_assign_bit_counter_unit
  import rabc_pkg::*;
#(
  parameter int unsigned POSITIONS = 1024,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data,      // size_in_use [10:0]
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,  // first_pos [10:0], last_pos [21:11],
                                           // mark_value [22], zero [23]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,  // set_count [10:0], zero [15:11]
  output logic              m_axis_tuser   // range_error [0]
);

  back_status_t status;
  logic         q_valid;
  entry_t       q_head;

  // Front: size register, classification and queue.
  rabc_front #(
    .POSITIONS(POSITIONS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .status       (status),
    .q_valid      (q_valid),
    .q_head       (q_head)
  );

  // Back: bitmap sweep, count and result register.
  rabc_back #(
    .POSITIONS(POSITIONS),
    .WORD_BITS(WORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .status       (status),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

[tb/testbench.sv]
module testbench;
  import rabc_pkg::*;

  // Block geometry, matching the instance below.
  localparam int unsigned POSITIONS = 1024;
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned NWORDS = (POSITIONS + WORD_BITS - 1) / WORD_BITS;

  // Run shape.
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 78;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [CNT_W-1:0] set_count;
    logic             range_error;
  } count_result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_SIZE
  } row_kind_t;

  // One line of the directed table: either a size write or a range transaction.
  typedef struct packed {
    row_kind_t         kind;
    logic [SIZE_W-1:0] size;
    logic [POS_W-1:0]  first;
    logic [POS_W-1:0]  last;
    logic              mark;
    logic              known;      // expected result given in the row
    logic [CNT_W-1:0]  exp_count;
    logic              exp_error;
  } stim_row_t;

  localparam int unsigned DIRECTED_LEN = 29;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    // Whole range after reset, then the rejected forms at full size.
    '{ROW_ITEM, 11'd0, 11'd1, 11'd1024, 1'b1, 1'b1, 11'd1024, 1'b0},
    '{ROW_ITEM, 11'd0, 11'd0, 11'd5, 1'b0, 1'b1, 11'd1024, 1'b1},
    '{ROW_ITEM, 11'd0, 11'd10, 11'd5, 1'b0, 1'b1, 11'd1024, 1'b1},
    '{ROW_ITEM, 11'd0, 11'd1, 11'd1025, 1'b0, 1'b1, 11'd1024, 1'b1},
    '{ROW_ITEM, 11'd0, 11'd2047, 11'd2047, 1'b1, 1'b1, 11'd1024, 1'b1},
    '{ROW_ITEM, 11'd0, 11'd0, 11'd0, 1'b1, 1'b1, 11'd1024, 1'b1},
    // Clear everything, then set the two end positions.
    '{ROW_ITEM, 11'd0, 11'd1, 11'd1024, 1'b0, 1'b1, 11'd0, 1'b0},
    '{ROW_ITEM, 11'd0, 11'd1024, 11'd1024, 1'b1, 1'b1, 11'd1, 1'b0},
    '{ROW_ITEM, 11'd0, 11'd1, 11'd1, 1'b1, 1'b1, 11'd2, 1'b0},
    // Ranges across word boundaries, plus a single position and an end beyond the size.
    '{ROW_ITEM, 11'd0, 11'd5, 11'd5, 1'b1, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, 11'd0, 11'd60, 11'd70, 1'b1, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, 11'd0, 11'd64, 11'd65, 1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, 11'd0, 11'd200, 11'd900, 1'b1, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, 11'd0, 11'd513, 11'd1024, 1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, 11'd0, 11'd3, 11'd2047, 1'b1, 1'b0, 11'd0, 1'b0},
    // A size of zero rejects everything and counts nothing; then small sizes.
    '{ROW_SIZE, 11'd0, 11'd0, 11'd0, 1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, 11'd0, 11'd1, 11'd1, 1'b1, 1'b1, 11'd0, 1'b1},
    '{ROW_SIZE, 11'd1, 11'd0, 11'd0, 1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, 11'd0, 11'd1, 11'd1, 1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, 11'd0, 11'd1, 11'd2, 1'b1, 1'b0, 11'd0, 1'b0},
    '{ROW_SIZE, 11'd10, 11'd0, 11'd0, 1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, 11'd0, 11'd1, 11'd10, 1'b1, 1'b0, 11'd0, 1'b0},
    // Sizes above the bitmap saturate to its length.
    '{ROW_SIZE, 11'd2047, 11'd0, 11'd0, 1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, 11'd0, 11'd1, 11'd1024, 1'b1, 1'b1, 11'd1024, 1'b0},
    '{ROW_ITEM, 11'd0, 11'd1, 11'd1025, 1'b1, 1'b1, 11'd1024, 1'b1},
    '{ROW_ITEM, 11'd0, 11'd1024, 11'd1023, 1'b0, 1'b1, 11'd1024, 1'b1},
    '{ROW_SIZE, 11'd1500, 11'd0, 11'd0, 1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, 11'd0, 11'd500, 11'd600, 1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_SIZE, 11'd1024, 11'd0, 11'd0, 1'b0, 1'b0, 11'd0, 1'b0}
  };

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata;   // first_pos [10:0], last_pos [21:11], mark_value [22]
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [15:0]       m_axis_tdata;   // set_count [10:0]
  logic              m_axis_tuser;   // range_error [0]

  // Shadow copy of the block's marks and size register.
  bit [WORD_BITS-1:0] mark_map [NWORDS];
  logic [SIZE_W-1:0]  size_reg;

  count_result_t pending_counts [$];
  int unsigned   mismatch_total;
  int unsigned   idle_cycles;
  int unsigned   burst_left;
  bit            hold_requested;

  range_assign_bit_counter_unit #(
    .POSITIONS(POSITIONS),
    .WORD_BITS(WORD_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Size actually applied: the register saturates at the bitmap length.
  function automatic int unsigned active_size();
    return (size_reg > POSITIONS) ? POSITIONS : int'(size_reg);
  endfunction

  // Applies one range to the shadow bitmap and recounts the positions in use.
  function automatic count_result_t apply_range(logic [POS_W-1:0] first,
                                                logic [POS_W-1:0] last, logic mark);
    int unsigned   lim;
    int unsigned   cnt;
    int unsigned   p;
    count_result_t res;
    lim = active_size();
    res.range_error = (first == 0) || (first > last) || (last > lim);
    if (!res.range_error) begin
      for (p = first; p <= last; p++) begin
        mark_map[(p - 1) / WORD_BITS][(p - 1) % WORD_BITS] = mark;
      end
    end
    cnt = 0;
    for (p = 0; p < lim; p++) begin
      cnt += mark_map[p / WORD_BITS][p % WORD_BITS];
    end
    res.set_count = CNT_W'(cnt);
    return res;
  endfunction

  // Sender helpers; each starts and ends on a falling edge.
  task automatic idle_for(input int unsigned cycles);
    s_axis_tvalid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending_counts.size() != 0) @(negedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    size_reg = value;
  endtask

  // Offers one range transaction in burst fashion and records what it must return.
  task automatic send_range(input logic [POS_W-1:0] first, input logic [POS_W-1:0] last,
                            input logic mark, input logic known,
                            input logic [CNT_W-1:0] exp_count, input logic exp_error);
    int unsigned   gap;
    count_result_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) idle_for(gap);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tdata = {1'b0, mark, last, first};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    res = apply_range(first, last, mark);
    if (known) begin
      res.set_count = exp_count;
      res.range_error = exp_error;
    end
    pending_counts.push_back(res);
  endtask

  // Random range: mostly legal ranges of varied length, the rest rejected forms.
  task automatic random_range();
    int unsigned lim;
    int unsigned pick;
    int unsigned f;
    int unsigned l;
    lim = active_size();
    pick = $urandom_range(0, 99);
    if (lim == 0 || pick >= 92) begin
      f = $urandom_range(0, 2047);
      l = $urandom_range(0, 2047);
    end else if (pick < 6) begin
      f = 1;
      l = lim;
    end else if (pick < 70) begin
      f = $urandom_range(1, lim);
      if ($urandom_range(0, 3) == 0) begin
        l = $urandom_range(f, lim);
      end else begin
        l = f + $urandom_range(0, 70);
        if (l > lim) l = lim;
      end
    end else if (pick < 80) begin
      l = $urandom_range(lim + 1, 2047);
      f = $urandom_range(1, l);
    end else if (pick < 87) begin
      f = $urandom_range(1, 2047);
      l = $urandom_range(0, f - 1);
    end else begin
      f = 0;
      l = $urandom_range(0, 2047);
    end
    send_range(POS_W'(f), POS_W'(l), 1'($urandom_range(0, 1)), 1'b0, '0, 1'b0);
  endtask

  // Stimulus: reset, directed table, then random phases under different sizes.
  initial begin
    int unsigned row;
    int unsigned phase;
    int unsigned item;
    int unsigned choice;
    logic [SIZE_W-1:0] next_size;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    hold_requested = 1'b0;
    burst_left = 0;
    mismatch_total = 0;
    size_reg = SIZE_RESET;
    for (row = 0; row < NWORDS; row++) mark_map[row] = '1;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    for (row = 0; row < DIRECTED_LEN; row++) begin
      if (DIRECTED_ROWS[row].kind == ROW_SIZE) begin
        write_size(DIRECTED_ROWS[row].size);
      end else begin
        send_range(DIRECTED_ROWS[row].first, DIRECTED_ROWS[row].last,
                   DIRECTED_ROWS[row].mark, DIRECTED_ROWS[row].known,
                   DIRECTED_ROWS[row].exp_count, DIRECTED_ROWS[row].exp_error);
      end
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      choice = (phase == 0) ? 0 : $urandom_range(0, 9);
      case (choice)
        4, 5:    next_size = SIZE_W'($urandom_range(1, 1024));
        6:       next_size = SIZE_W'($urandom_range(1, 40));
        7:       next_size = SIZE_W'($urandom_range(1025, 2047));
        8:       next_size = '0;
        9:       next_size = '1;
        default: next_size = SIZE_W'(POSITIONS);
      endcase
      write_size(next_size);
      for (item = 0; item < ITEMS_PER_PHASE; item++) begin
        // Let the output side back up so that the input stalls.
        if (phase == 2 && item == 10) hold_requested = 1'b1;
        // Stop sending until every outstanding result has been returned.
        if (phase == 5 && item == 40) wait_drained();
        random_range();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_total == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Output side: a sequence of changing stall patterns, plus one long hold.
  initial begin
    int unsigned mode;
    int unsigned period;
    int unsigned k;
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_requested) begin
        m_axis_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_requested = 1'b0;
      end
      mode = $urandom_range(0, 3);
      period = $urandom_range(2, 5);
      for (k = 0; k < 40; k++) begin
        case (mode)
          0:       m_axis_tready = 1'b1;
          1:       m_axis_tready = ($urandom_range(0, 3) != 0);
          2:       m_axis_tready = ((k % period) == 0);
          default: m_axis_tready = 1'($urandom_range(0, 1));
        endcase
        @(negedge clk);
      end
    end
  end

  // Result checking and the inactivity watchdog.
  always @(posedge clk) begin
    count_result_t want;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_counts.size() == 0) begin
        $error("result transaction with no expectation waiting: set_count %0d, range_error %0d",
               m_axis_tdata[CNT_W-1:0], m_axis_tuser);
        mismatch_total++;
      end else begin
        want = pending_counts.pop_front();
        if (m_axis_tdata[CNT_W-1:0] !== want.set_count) begin
          $error("set_count: expected %0d, actual %0d", want.set_count,
                 m_axis_tdata[CNT_W-1:0]);
          mismatch_total++;
        end
        if (m_axis_tuser !== want.range_error) begin
          $error("range_error: expected %0d, actual %0d", want.range_error, m_axis_tuser);
          mismatch_total++;
        end
      end
    end
  end

endmodule

[sim.f]
+incdir+rtl
rtl/rabc_pkg.sv
rtl/rabc_ram.sv
rtl/rabc_back.sv
rtl/rabc_front.sv
rtl/range_assign_bit_counter_unit.sv
tb/testbench.sv
